// ===== rtl/core/ccp_pkg.sv =====
// Shared constants, types and table-building functions for the log cosine palette.
// No dependencies. Used by the top level and both ROM modules.
`default_nettype none

package ccp_pkg;

  typedef longint unsigned u64_t;

  // Defaults for the table sizes.
  localparam int unsigned COS_POINTS_DEF = 1024;
  localparam int unsigned LOG_POINTS_DEF = 256;

  localparam int unsigned FRAC_BITS_W   = 6;
  localparam logic [FRAC_BITS_W-1:0] FRAC_BITS_RST = 6'd32;
  localparam int unsigned LOG_FRAC_W    = 24;

  localparam u64_t ONE_Q30    = 64'd1073741824;
  localparam u64_t TWO_PI_Q30 = 64'd6746518852;

  // ln2 in Q0.32, reciprocal of 3 for x/3 = (x * DIV3_Q33) >> 33
  localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;
  localparam logic [31:0] DIV3_Q33 = 32'hAAAA_AAAB;

  // s/(2pi) in Q0.32 per channel
  localparam logic [29:0] K_RED_Q32   = 30'd683565276;
  localparam logic [29:0] K_GREEN_Q32 = 30'd161117881;
  localparam logic [29:0] K_BLUE_Q32  = 30'd85122000;

  // Palette entry from a folded angle (Q30 radians in [0, pi/2]).
  function automatic logic [7:0] cos_entry(input u64_t ang, input bit neg);
    u64_t    a2;
    u64_t    term;
    u64_t    d;
    longint  sum;
    int      k;
    a2   = (ang * ang) >> 30;
    term = ONE_Q30;
    sum  = 0;
    for (k = 0; k < 12; k++) begin
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
      term = (term * a2) >> 30;
      case (k)
        0:       term = term / 2;
        1:       term = term / 12;
        2:       term = term / 30;
        3:       term = term / 56;
        4:       term = term / 90;
        5:       term = term / 132;
        6:       term = term / 182;
        7:       term = term / 240;
        8:       term = term / 306;
        9:       term = term / 380;
        10:      term = term / 462;
        default: term = term / 552;
      endcase
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    if (sum < -longint'(ONE_Q30)) begin
      sum = -longint'(ONE_Q30);
    end
    if (neg) begin
      sum = -sum;
    end
    d = u64_t'(longint'(ONE_Q30) - sum);
    return 8'((u64_t'(255) * d) >> 31);
  endfunction

  // log2 fraction in Q0.24 by bit-serial squaring of a Q1.30 mantissa.
  function automatic logic [LOG_FRAC_W-1:0] log_entry(input u64_t m0);
    u64_t                  m;
    logic [LOG_FRAC_W-1:0] res;
    int                    s;
    m   = m0;
    res = '0;
    for (s = 0; s < LOG_FRAC_W; s++) begin
      m   = (m * m) >> 30;
      res = {res[LOG_FRAC_W-2:0], 1'b0};
      if (m >= 2 * ONE_Q30) begin
        m      = m >> 1;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccp_log_rom.sv =====
// Log2 fraction ROM, Q0.24 entries, registered read with load enable.
// Depends on ccp_pkg (log_entry).
`default_nettype none

module ccp_log_rom #(
  parameter int unsigned POINTS = ccp_pkg::LOG_POINTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [$clog2(POINTS)-1:0]         addr_i,
  output      logic [ccp_pkg::LOG_FRAC_W-1:0]    data_o
);

  localparam ccp_pkg::u64_t NL = ccp_pkg::u64_t'(POINTS);

  logic [ccp_pkg::LOG_FRAC_W-1:0] rom [POINTS];
  logic [ccp_pkg::LOG_FRAC_W-1:0] data_q;

  for (genvar g = 0; g < POINTS; g++) begin : g_ent
    localparam ccp_pkg::u64_t M0 = ((NL + ccp_pkg::u64_t'(g)) << 30) / NL;
    assign rom[g] = ccp_pkg::log_entry(M0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ccp_cos_rom.sv =====
// Cosine palette ROM over one turn, 8-bit intensities, registered read with load enable.
// Depends on ccp_pkg (cos_entry, TWO_PI_Q30).
`default_nettype none

module ccp_cos_rom #(
  parameter int unsigned POINTS = ccp_pkg::COS_POINTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [$clog2(POINTS)-1:0] addr_i,
  output      logic [7:0]                data_o
);

  localparam ccp_pkg::u64_t NL = ccp_pkg::u64_t'(POINTS);

  logic [7:0] rom [POINTS];
  logic [7:0] data_q;

  // fold the angle into the first quadrant; second quadrant flips sign
  for (genvar g = 0; g < POINTS; g++) begin : g_ent
    localparam ccp_pkg::u64_t IDX  = ccp_pkg::u64_t'(g);
    localparam ccp_pkg::u64_t NUM0 = (2 * IDX > NL) ? NL - IDX : IDX;
    localparam bit            FOLD = (4 * NUM0 > NL);
    localparam ccp_pkg::u64_t NUM  = FOLD ? NL - 2 * NUM0 : NUM0;
    localparam ccp_pkg::u64_t DEN  = FOLD ? 2 * NL : NL;
    localparam ccp_pkg::u64_t ANG  = (ccp_pkg::TWO_PI_Q30 * NUM) / DEN;
    assign rom[g] = ccp_pkg::cos_entry(ANG, FOLD);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/log_cosine_color_palette_unit.sv =====
// Top level of the log cosine color palette: 12-stage pipeline, level in, RGB out.
// Depends on ccp_pkg, ccp_log_rom and ccp_cos_rom.
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  ---------------------------
//  in       in         in_valid_i / in_stall_o     level_i[63:0]
//  out      out        out_valid_o / out_stall_i   red_o, green_o, blue_o [7:0]
//  cfg      in         cfg_we_i (no wait)          cfg_wdata_i[5:0] = frac_bits
//
// One request per cycle sustained while out_stall_i is low; a request passes through every
// pipeline register before out_valid_o rises for it.
// Depth is set by the leading-one search, the 64-bit normalize shift, the split index
// multiply, the log ROM port, the ln2, divide-by-3 and per-channel multipliers, and the
// cosine ROM ports. rst_ni (async, active low) empties the pipe and sets frac_bits to 32;
// the ROMs are constant and need no clearing. Each stage holds only while it is full and
// the stage after it holds, so bubbles close up and a stalled output keeps input open
// until every stage is full.
`default_nettype none

module log_cosine_color_palette_unit #(
  parameter int unsigned COS_POINTS       = ccp_pkg::COS_POINTS_DEF,
  parameter int unsigned LOG_TABLE_POINTS = ccp_pkg::LOG_POINTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccp_pkg::FRAC_BITS_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [63:0]                     level_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [7:0]                      red_o,
  output      logic [7:0]                      green_o,
  output      logic [7:0]                      blue_o
);

  localparam int unsigned NS    = 12;                           // pipeline stages
  localparam int unsigned LW    = $clog2(LOG_TABLE_POINTS + 1); // table size as a factor
  localparam int unsigned IW    = $clog2(LOG_TABLE_POINTS);     // log ROM address
  localparam int unsigned CW    = $clog2(COS_POINTS + 1);
  localparam int unsigned AW    = $clog2(COS_POINTS);           // cos ROM address
  localparam int unsigned SUM_W = 47 + LW;
  localparam int unsigned CP_W  = 32 + CW;
  localparam int unsigned LF    = ccp_pkg::LOG_FRAC_W;

  localparam logic [LW-1:0] LTP_C = LW'(LOG_TABLE_POINTS);
  localparam logic [CW-1:0] CP_C  = CW'(COS_POINTS);
  localparam logic [29:0]   CHAN_K [3] = '{ccp_pkg::K_RED_Q32, ccp_pkg::K_GREEN_Q32,
                                           ccp_pkg::K_BLUE_Q32};

  // ---------------------------------------------------------------- config
  logic [ccp_pkg::FRAC_BITS_W-1:0] frac_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q <= ccp_pkg::FRAC_BITS_RST;
    end else if (cfg_we_i) begin
      frac_bits_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- flow control
  // v_q[k] is the valid bit of stage k+1; en[k] loads that stage.
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  // ---------------------------------------------------------------- datapath
  // stage 1: per-16-bit leading-one position
  logic [63:0]      lvl1_q;
  logic [3:0][3:0]  cidx1_q, cidx1_d;
  logic [3:0]       cnz1_q, cnz1_d;
  // stage 2: leading-one index of the whole word
  logic [63:0]      lvl2_q;
  logic [5:0]       p2_q, p2_d;
  logic             zero2_q;
  // stage 3: normalized fraction bits below the leading one
  logic [46:0]      x3_q;
  logic [63:0]      shifted3;
  logic [5:0]       p3_q;
  logic             zero3_q;
  // stage 4: partial products of fraction times table size
  logic [32+LW-1:0] hi4_q;
  logic [15+LW-1:0] lo4_q;
  logic [5:0]       p4_q;
  logic             zero4_q;
  // stage 5: table index
  logic [SUM_W-1:0] sum5;
  logic [IW-1:0]    lidx5_q;
  logic [5:0]       p5_q;
  logic             zero5_q;
  // stage 6: log ROM output
  logic [LF-1:0]    lut6;
  logic [5:0]       p6_q;
  logic             zero6_q;
  // stage 7: |log2| in Q6.24
  logic [6:0]       diff7;
  logic [31:0]      l2_7, abs7;
  logic [29:0]      mag7_q;
  logic             zero7_q;
  // stage 8: |ln|
  logic [61:0]      ln_prod;
  logic [29:0]      ln8_q;
  logic             zero8_q;
  // stage 9: phase = ln / 3
  logic [61:0]      ph_prod;
  logic [27:0]      ph9_q;
  logic             zero9_q;
  // stage 10: fractional turns per channel
  logic [57:0]      t_prod [3];
  logic [31:0]      fr10_q [3];
  logic             zero10_q;
  // stage 11: cos ROM address per channel
  logic [CP_W-1:0]  c_prod [3];
  logic [AW-1:0]    ci11_q [3];
  logic             zero11_q;
  // stage 12: palette values
  logic [7:0]       col12 [3];
  logic             zero12_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cidx1_d[c] = '0;
      cnz1_d[c]  = |level_i[16*c +: 16];
      for (int b = 0; b < 16; b++) begin
        if (level_i[16*c + b]) begin
          cidx1_d[c] = 4'(b);
        end
      end
    end
  end

  always_comb begin
    p2_d = {2'd0, cidx1_q[0]};
    for (int c = 1; c < 4; c++) begin
      if (cnz1_q[c]) begin
        p2_d = {2'(c), cidx1_q[c]};
      end
    end
  end

  assign shifted3 = lvl2_q << (6'd63 - p2_q);
  assign sum5     = {hi4_q, 15'd0} + SUM_W'(lo4_q);
  assign diff7    = {1'b0, p6_q} - {1'b0, frac_bits_q};
  assign l2_7     = {diff7[6], diff7, 24'd0} + {8'd0, lut6};
  assign abs7     = l2_7[31] ? (32'd0 - l2_7) : l2_7;
  assign ln_prod  = 62'(mag7_q) * 62'(ccp_pkg::LN2_Q32);
  assign ph_prod  = 62'(ln8_q) * 62'(ccp_pkg::DIV3_Q33);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t_prod[c] = 58'(ph9_q) * 58'(CHAN_K[c]);
      c_prod[c] = CP_W'(fr10_q[c]) * CP_W'(CP_C);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lvl1_q  <= level_i;
      cidx1_q <= cidx1_d;
      cnz1_q  <= cnz1_d;
    end
    if (en[1]) begin
      lvl2_q  <= lvl1_q;
      p2_q    <= p2_d;
      zero2_q <= ~|cnz1_q;
    end
    if (en[2]) begin
      x3_q    <= shifted3[62:16];
      p3_q    <= p2_q;
      zero3_q <= zero2_q;
    end
    if (en[3]) begin
      hi4_q   <= (32 + LW)'(x3_q[46:15]) * (32 + LW)'(LTP_C);
      lo4_q   <= (15 + LW)'(x3_q[14:0]) * (15 + LW)'(LTP_C);
      p4_q    <= p3_q;
      zero4_q <= zero3_q;
    end
    if (en[4]) begin
      lidx5_q <= sum5[47 +: IW];
      p5_q    <= p4_q;
      zero5_q <= zero4_q;
    end
    if (en[5]) begin
      p6_q    <= p5_q;
      zero6_q <= zero5_q;
    end
    if (en[6]) begin
      mag7_q  <= abs7[29:0];
      zero7_q <= zero6_q;
    end
    if (en[7]) begin
      ln8_q   <= ln_prod[61:32];
      zero8_q <= zero7_q;
    end
    if (en[8]) begin
      ph9_q   <= ph_prod[60:33];
      zero9_q <= zero8_q;
    end
    if (en[9]) begin
      for (int c = 0; c < 3; c++) begin
        fr10_q[c] <= t_prod[c][55:24];
      end
      zero10_q <= zero9_q;
    end
    if (en[10]) begin
      for (int c = 0; c < 3; c++) begin
        ci11_q[c] <= c_prod[c][32 +: AW];
      end
      zero11_q <= zero10_q;
    end
    if (en[11]) begin
      zero12_q <= zero11_q;
    end
  end

  ccp_log_rom #(
    .POINTS (LOG_TABLE_POINTS)
  ) u_log_rom (
    .clk_i  (clk_i),
    .en_i   (en[5]),
    .addr_i (lidx5_q),
    .data_o (lut6)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    ccp_cos_rom #(
      .POINTS (COS_POINTS)
    ) u_cos_rom (
      .clk_i  (clk_i),
      .en_i   (en[11]),
      .addr_i (ci11_q[c]),
      .data_o (col12[c])
    );
  end

  // zero level is black
  assign red_o   = zero12_q ? 8'd0 : col12[0];
  assign green_o = zero12_q ? 8'd0 : col12[1];
  assign blue_o  = zero12_q ? 8'd0 : col12[2];

`ifndef ASSERT_OFF
  // input only stalls when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // leading-one search: nothing set above p
  a_lead_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && !zero2_q) |-> ((lvl2_q >> p2_q) == 64'd1))
    else $error("leading-one index wrong");

  // log table index stays within the table
  a_lidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (32'(lidx5_q) < 32'(LOG_TABLE_POINTS)))
    else $error("log table index out of range");

  // frac_bits changes only through a write
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(frac_bits_q))
    else $error("frac_bits changed without a write");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for log_cosine_color_palette_unit: random and directed escape levels
// under several frac_bits settings and handshake pressure, checked against a local predictor.
// Depends on ccp_pkg (port widths) and the RTL of the palette unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COS_N    = ccp_pkg::COS_POINTS_DEF;
  localparam int unsigned LOG_N    = ccp_pkg::LOG_POINTS_DEF;
  localparam int unsigned CI_W     = $clog2(COS_N);
  localparam int unsigned LI_W     = $clog2(LOG_N);
  localparam int unsigned FB_W     = ccp_pkg::FRAC_BITS_W;
  localparam int          WATCHDOG = 3000;
  localparam int          HOLD_LEN = 300;
  localparam int          DRAIN_WAIT = 20;

  // Fixed-point constants of the palette math.
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;
  localparam logic [63:0] Q32_LN2    = 64'hB172_17F8;
  localparam logic [63:0] RATE_RED   = 64'd683565276;
  localparam logic [63:0] RATE_GREEN = 64'd161117881;
  localparam logic [63:0] RATE_BLUE  = 64'd85122000;
  localparam logic [63:0] TURN_MASK  = 64'h00FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [FB_W-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [63:0]     level_i     = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      red_o;
  logic [7:0]      green_o;
  logic [7:0]      blue_o;

  log_cosine_color_palette_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always #1 clk_i = ~clk_i;

  // Lookup tables rebuilt locally: palette shade per cosine step, log2 fraction per
  // mantissa step.
  logic [7:0]  shade_lut [COS_N];
  logic [23:0] log2_lut  [LOG_N];

  logic [FB_W-1:0] frac_model = FB_W'(32);  // mirrors the frac_bits register
  rgb_t            expected_rgb [$];
  logic [63:0]     pending_level [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_begun    = 1'b0;
  int hold_left     = 0;
  bit req_taken     = 1'b0;
  int idle_cycles   = 0;
  int errors        = 0;
  int req_count     = 0;
  int black_count   = 0;
  int color_count   = 0;
  int settings_seen = 1;

  // Shade for cosine step i: fold into the first quadrant, Taylor series in Q30,
  // then 255 * (1 - cos) / 2.
  function automatic logic [7:0] shade_of(input int unsigned i);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] gap;
    longint      acc;
    bit          flip;
    int          k;
    num  = 64'(i);
    den  = 64'(COS_N);
    flip = 1'b0;
    acc  = 0;
    if (2 * num > 64'(COS_N)) begin
      num = 64'(COS_N) - num;
    end
    if (4 * num > 64'(COS_N)) begin
      num  = 64'(COS_N) - 2 * num;
      den  = 2 * 64'(COS_N);
      flip = 1'b1;
    end
    ang    = (Q30_TWO_PI * num) / den;
    ang_sq = (ang * ang) >> 30;
    term   = Q30_ONE;
    for (k = 0; k < 12; k++) begin
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
      term = (term * ang_sq) >> 30;
      term = term / 64'((2 * k + 1) * (2 * k + 2));
    end
    if (acc > longint'(Q30_ONE)) begin
      acc = longint'(Q30_ONE);
    end
    if (acc < -longint'(Q30_ONE)) begin
      acc = -longint'(Q30_ONE);
    end
    if (flip) begin
      acc = -acc;
    end
    gap = 64'(longint'(Q30_ONE) - acc);
    return 8'((64'd255 * gap) >> 31);
  endfunction

  // log2(1 + i/LOG_N) in Q0.24 by repeated squaring of the mantissa.
  function automatic logic [23:0] log2_frac_of(input int unsigned i);
    logic [63:0] m;
    logic [23:0] acc;
    int          s;
    m   = (64'(LOG_N + i) << 30) / 64'(LOG_N);
    acc = '0;
    for (s = 0; s < 24; s++) begin
      m   = (m * m) >> 30;
      acc = acc << 1;
      if (m >= 2 * Q30_ONE) begin
        m      = m >> 1;
        acc[0] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] hue_of(input logic [63:0] phase, input logic [63:0] rate);
    logic [63:0] turns;
    logic [63:0] frac;
    logic [63:0] step;
    turns = phase * rate;
    frac  = (turns & TURN_MASK) >> 24;
    step  = (frac * 64'(COS_N)) >> 32;
    return shade_lut[step[CI_W-1:0]];
  endfunction

  function automatic rgb_t paint(input logic [63:0] level, input logic [FB_W-1:0] fb);
    rgb_t        color;
    int          msb;
    logic [63:0] mant;
    logic [63:0] idx;
    logic [63:0] mag;
    logic [63:0] phase;
    longint      l2;
    color = '0;
    if (level == 64'd0) begin
      return color;
    end
    msb = 63;
    while (!level[msb[5:0]]) begin
      msb--;
    end
    mant  = (level << (63 - msb)) & 64'h7FFF_FFFF_FFFF_FFFF;
    idx   = ((mant >> 16) * 64'(LOG_N)) >> 47;
    l2    = longint'(msb - int'(fb)) * 64'sd16777216 + longint'(log2_lut[idx[LI_W-1:0]]);
    mag   = (l2 < 0) ? 64'(-l2) : 64'(l2);
    phase = ((mag * Q32_LN2) >> 32) / 3;
    color.red   = hue_of(phase, RATE_RED);
    color.green = hue_of(phase, RATE_GREEN);
    color.blue  = hue_of(phase, RATE_BLUE);
    return color;
  endfunction

  // Random level mix: black, exactly one, values just around one, single bits,
  // all ones, full-width noise and noise with a random leading-bit position.
  function automatic logic [63:0] pick_level(input logic [FB_W-1:0] fb);
    logic [63:0] noise;
    logic [63:0] one;
    noise = {$urandom, $urandom};
    one   = 64'd1 << fb;
    case ($urandom_range(0, 15))
      0:       return 64'd0;
      1:       return one;
      2:       return one + 64'($urandom_range(0, 8)) - 64'd4;
      3:       return 64'd1 << $urandom_range(0, 63);
      4:       return '1;
      5, 6:    return noise;
      default: return noise >> $urandom_range(0, 63);
    endcase
  endfunction

  // Request driver: valid only drops after a request was taken, never on stall.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_level.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        level_i    <= pending_level.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: one long hold when asked, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_req && !hold_begun) begin
      hold_begun  <= 1'b1;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Predict on each accepted request, check each accepted color, track the
  // register, and watch for a stuck handshake.
  always @(posedge clk_i) begin
    rgb_t want;
    bit   out_fire;
    req_taken = in_valid_i && !in_stall_o;
    out_fire  = out_valid_o && !out_stall_i;
    if (cfg_we_i) begin
      frac_model = cfg_wdata_i;
    end
    if (req_taken) begin
      expected_rgb.push_back(paint(level_i, frac_model));
      req_count++;
      if (level_i == 64'd0) begin
        black_count++;
      end
    end
    if (out_fire) begin
      color_count++;
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected color %0d/%0d/%0d", $time, red_o, green_o, blue_o);
        errors++;
      end else begin
        want = expected_rgb.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red expected %0d got %0d", $time, want.red, red_o);
          errors++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %0d got %0d", $time, want.green, green_o);
          errors++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, want.blue, blue_o);
          errors++;
        end
      end
    end
    if (req_taken || out_fire || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no handshake for %0d cycles, %0d colors outstanding",
               $time, WATCHDOG, expected_rgb.size());
      $display("log_cosine_color_palette_unit test failed");
      $finish;
    end
  end

  // Wait until every queued request went in and every color came back.
  task automatic drain();
    while (pending_level.size() != 0 || in_valid_i || expected_rgb.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_frac(input logic [FB_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_seen++;
  endtask

  // One random phase; with a midpoint pause the sender stops until the pipe is empty.
  task automatic run_phase(input int count, input logic [FB_W-1:0] fb, input bit midpoint_pause);
    int i;
    for (i = 0; i < count; i++) begin
      if (midpoint_pause && i == count / 2) begin
        drain();
      end
      pending_level.push_back(pick_level(fb));
    end
    drain();
  endtask

  initial begin
    logic [FB_W-1:0] fb;
    int              i;
    for (i = 0; i < COS_N; i++) begin
      shade_lut[i[CI_W-1:0]] = shade_of(i);
    end
    for (i = 0; i < LOG_N; i++) begin
      log2_lut[i[LI_W-1:0]] = log2_frac_of(i);
    end

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed levels at the reset setting of 32 fractional bits.
    pending_level.push_back(64'd0);
    pending_level.push_back(64'h0000_0001_0000_0000);  // exactly one: black too
    pending_level.push_back(64'd1);
    pending_level.push_back(64'd2);
    pending_level.push_back(64'd3);
    pending_level.push_back('1);
    pending_level.push_back(64'h8000_0000_0000_0000);
    pending_level.push_back(64'h8000_0000_0000_0001);
    pending_level.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_level.push_back(64'h0000_0000_FFFF_FFFF);
    pending_level.push_back(64'h0000_0001_0000_0001);
    pending_level.push_back(64'h5555_5555_5555_5555);
    pending_level.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_level.push_back(64'h0000_0002_B7E1_5162);  // roughly e
    pending_level.push_back(64'h0000_0000_5E2D_58D9);  // roughly 1/e
    pending_level.push_back(64'h0000_1000_0000_0000);
    pending_level.push_back(64'h0000_0000_0000_1000);
    pending_level.push_back(64'h0000_0001_FFFF_FFFF);
    drain();

    // Lowest setting: a level of one is the integer 1.
    write_frac('0);
    pending_level.push_back(64'd1);
    pending_level.push_back(64'd0);
    run_phase(300, '0, 1'b0);

    // Highest setting, sparse sender.
    send_idle_pct = 84;
    write_frac('1);
    pending_level.push_back(64'h8000_0000_0000_0000);
    run_phase(300, '1, 1'b0);

    // Sender flat out into a stalling receiver, opened by one long hold so the
    // pipe fills and stalls its input.
    send_idle_pct = 0;
    stall_pct     = 84;
    write_frac(FB_W'(17));
    hold_req = 1'b1;
    run_phase(300, FB_W'(17), 1'b0);

    // Light idling on both sides, with a full drain half way.
    send_idle_pct = 21;
    stall_pct     = 21;
    fb = FB_W'($urandom_range(1, 62));
    write_frac(fb);
    run_phase(300, fb, 1'b1);

    // Back to the reset value, no idling.
    send_idle_pct = 0;
    stall_pct     = 0;
    write_frac(FB_W'(32));
    run_phase(300, FB_W'(32), 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_rgb.size() != 0) begin
      $display("%0t: %0d colors never arrived", $time, expected_rgb.size());
      errors++;
    end

    $display("Ran %0d levels (%0d zero) over %0d frac_bits settings; %0d colors compared.",
             req_count, black_count, settings_seen, color_count);
    $display("Idle mixes: none, sender 84%%, receiver 84%% with a long hold, both 21%%.");
    if (errors == 0) begin
      $display("log_cosine_color_palette_unit test passed");
    end else begin
      $display("log_cosine_color_palette_unit test failed");
    end
    $finish;
  end

endmodule
